FILE: hdl/cell_water_balance_assert.svh
// assertion macros for the cell water balance pipeline
// depends on nothing; included inside module bodies
`ifndef CELL_WATER_BALANCE_ASSERT_SVH
`define CELL_WATER_BALANCE_ASSERT_SVH
// implication checked on every clock, off during reset
`define CWB_ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("cwb check failed");
// next-cycle implication
`define CWB_ASSERT_NXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("cwb check failed");
`endif

FILE: hdl/cwb_pkg.sv
// package for the cell water balance block
// constants and a saturating add helper, no dependencies
package cwb_pkg;
	localparam int AMT_W = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int DIV_W = 33;
	typedef logic [AMT_W-1:0] amt_t;

	function automatic amt_t sat_add(input amt_t a, input amt_t b);
		logic [AMT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		sat_add = s[AMT_W] ? '1 : s[AMT_W-1:0];
	endfunction
endpackage

FILE: hdl/cwb_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on cwb_pkg; carries a side payload along with the operands
module cwb_div #(
	parameter int NW = 64,
	parameter int DW = cwb_pkg::DIV_W,
	parameter int QW = 32,
	parameter int PW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_vld,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [PW-1:0] pay,
	output logic          out_vld,
	output logic [QW-1:0] quo,
	output logic [PW-1:0] pay_out
);
	import cwb_pkg::*;
	// numerator is below den * 2^QW, so QW quotient bits suffice
	// the high part of the numerator preloads the remainder, the low QW bits shift in
	logic [QW:0]        vld_s;
	logic [DW-1:0]      rem_s [QW+1];
	logic [NW-1:0]      nsh_s [QW+1];
	logic [DW-1:0]      den_s [QW+1];
	logic [QW-1:0]      quo_s [QW+1];
	logic [PW-1:0]      pay_s [QW+1];

	always_comb begin
		vld_s[0] = in_vld;
		rem_s[0] = DW'(num[NW-1:QW]);
		nsh_s[0] = num << QW;
		den_s[0] = den;
		quo_s[0] = '0;
		pay_s[0] = pay;
	end

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DW:0] trial;
		assign trial = {rem_s[k], nsh_s[k][NW-1]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (trial >= {1'b0, den_s[k]}) begin
				rem_s[k+1] <= DW'(trial - {1'b0, den_s[k]});
				quo_s[k+1] <= {quo_s[k][QW-2:0], 1'b1};
			end else begin
				rem_s[k+1] <= trial[DW-1:0];
				quo_s[k+1] <= {quo_s[k][QW-2:0], 1'b0};
			end
			nsh_s[k+1] <= {nsh_s[k][NW-2:0], 1'b0};
			den_s[k+1] <= den_s[k];
			pay_s[k+1] <= pay_s[k];
		end
	end

	assign out_vld = vld_s[QW];
	assign quo = quo_s[QW];
	assign pay_out = pay_s[QW];
endmodule

FILE: hdl/cell_water_balance.sv
// cell water balance top level: scale, interception, evapotranspiration split,
// infiltration and ponding; depends on cwb_pkg, cwb_div, cell_water_balance_assert.svh
//
// usage
//   one cell word is taken at each clock edge with start high and busy low.
//   busy is tied low: the pipeline takes a cell every cycle, no stalls.
//   results leave in the same order on the result ports, marked by done
//   for exactly one cycle; the receiver cannot hold them off.
// pipeline
//   from accept to done: 1 input register, 1 multiply stage,
//   1 interception stage, 1 surface sum / total stage, 32 divider stages
//   (one quotient bit each, the split of evapotranspiration E*I/T) and
//   1 output stage that does infiltration and ponding.
// throughput
//   one cell per cycle, set by the one-bit-per-stage divider pipeline.
// reset
//   arst_n clears the stage valid bits and done, not out_valid; words in flight
//   are dropped, no result is produced for them. no clearing pass, no storage.
// invalid cells ride the same pipeline and return their echoes.
module cell_water_balance #(
	parameter int FRAC_BITS = cwb_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               cell_valid,
	input  cwb_pkg::amt_t      step_time,
	input  cwb_pkg::amt_t      precip_rate,
	input  cwb_pkg::amt_t      evap_rate,
	input  cwb_pkg::amt_t      infil_rate,
	input  cwb_pkg::amt_t      intercept_store,
	input  cwb_pkg::amt_t      intercept_cap,
	input  cwb_pkg::amt_t      routed_flow,
	input  cwb_pkg::amt_t      ponding_store,
	input  cwb_pkg::amt_t      ponding_cap,
	output logic               done,
	output logic               out_valid,
	output cwb_pkg::amt_t      new_intercept,
	output cwb_pkg::amt_t      infil_added,
	output cwb_pkg::amt_t      new_ponding,
	output cwb_pkg::amt_t      new_flow
);
	import cwb_pkg::*;
	`include "cell_water_balance_assert.svh"

	localparam int PROD_W = 2 * AMT_W;

	// payload riding the divider: everything the last stage needs
	typedef struct packed {
		logic cv;
		logic qz;    // surface water was zero
		logic eall;  // evap takes everything
		amt_t e;
		amt_t i;
		amt_t q;
		amt_t f;
		amt_t pcap;
		amt_t istore;
		amt_t pstore;
		amt_t routed;
	} dpay_t;
	localparam int PW = $bits(dpay_t);

	assign busy = 1'b0;

	// stage 1: register inputs
	logic s1_v;
	logic cv_s1;
	amt_t st_s1, pr_s1, er_s1, fr_s1, is_s1, ic_s1, rf_s1, ps_s1, pc_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else begin
			s1_v <= start & ~busy;
		end
	end
	always_ff @(posedge clk) begin
		cv_s1 <= cell_valid;
		st_s1 <= step_time;
		pr_s1 <= precip_rate;
		er_s1 <= evap_rate;
		fr_s1 <= infil_rate;
		is_s1 <= intercept_store;
		ic_s1 <= intercept_cap;
		rf_s1 <= routed_flow;
		ps_s1 <= ponding_store;
		pc_s1 <= ponding_cap;
	end

	// stage 2: the three rate products, 32x32 each
	logic s2_v;
	logic cv_s2;
	logic [PROD_W-1:0] pp_s2, ep_s2, fp_s2;
	amt_t is_s2, ic_s2, rf_s2, ps_s2, pc_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v <= 1'b0;
		end else begin
			s2_v <= s1_v;
		end
	end
	always_ff @(posedge clk) begin
		cv_s2 <= cv_s1;
		pp_s2 <= PROD_W'(st_s1) * PROD_W'(pr_s1);
		ep_s2 <= PROD_W'(st_s1) * PROD_W'(er_s1);
		fp_s2 <= PROD_W'(st_s1) * PROD_W'(fr_s1);
		is_s2 <= is_s1;
		ic_s2 <= ic_s1;
		rf_s2 <= rf_s1;
		ps_s2 <= ps_s1;
		pc_s2 <= pc_s1;
	end

	// shift and saturate a product
	function automatic amt_t scale_sat(input logic [PROD_W-1:0] p);
		logic [PROD_W-1:0] s;
		s = p >> FRAC_BITS;
		scale_sat = (s[PROD_W-1:AMT_W] != '0) ? '1 : s[AMT_W-1:0];
	endfunction

	// stage 3: scale the products, interception fill or spill of an overfull store
	amt_t p2, e2, f2, i3, p3;
	always_comb begin
		amt_t g;
		p2 = scale_sat(pp_s2);
		e2 = scale_sat(ep_s2);
		f2 = scale_sat(fp_s2);
		g = '0;
		i3 = is_s2;
		p3 = p2;
		if (ic_s2 != '0) begin
			if (is_s2 < ic_s2) begin
				g = ic_s2 - is_s2;
				if (g > p2) begin
					g = p2;
				end
				i3 = is_s2 + g;
				p3 = p2 - g;
			end else begin
				p3 = sat_add(p2, is_s2 - ic_s2);
				i3 = ic_s2;
			end
		end
	end

	logic s3_v;
	logic cv_s3;
	amt_t p_s3, e_s3, f_s3, i_s3, is_s3, rf_s3, ps_s3, pc_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_v <= 1'b0;
		end else begin
			s3_v <= s2_v;
		end
	end
	always_ff @(posedge clk) begin
		cv_s3 <= cv_s2;
		p_s3 <= p3;
		e_s3 <= e2;
		f_s3 <= f2;
		i_s3 <= i3;
		is_s3 <= is_s2;
		rf_s3 <= rf_s2;
		ps_s3 <= ps_s2;
		pc_s3 <= pc_s2;
	end

	// stage 4: surface sum, total, evap product
	amt_t q4;
	logic [DIV_W-1:0] t4;
	always_comb begin
		q4 = sat_add(sat_add(p_s3, rf_s3), ps_s3);
		t4 = {1'b0, i_s3} + {1'b0, q4};
	end

	logic s4_v;
	dpay_t pay_s4;
	logic [PROD_W-1:0] ei_s4;
	logic [DIV_W-1:0] t_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s4_v <= 1'b0;
		end else begin
			s4_v <= s3_v;
		end
	end
	always_ff @(posedge clk) begin
		pay_s4.cv <= cv_s3;
		pay_s4.qz <= (q4 == '0);
		pay_s4.eall <= ({1'b0, e_s3} >= t4);
		pay_s4.e <= e_s3;
		pay_s4.i <= i_s3;
		pay_s4.q <= q4;
		pay_s4.f <= f_s3;
		pay_s4.pcap <= pc_s3;
		pay_s4.istore <= is_s3;
		pay_s4.pstore <= ps_s3;
		pay_s4.routed <= rf_s3;
		ei_s4 <= PROD_W'(e_s3) * PROD_W'(i_s3);
		// a zero total only happens when q is zero, divider result unused then
		t_s4 <= (t4 == '0) ? DIV_W'(1) : t4;
	end

	// e*i/t: quotient fits 32 bits since i < t whenever it is used
	logic  dv_v;
	amt_t  ei_q;
	dpay_t dp;
	logic [PW-1:0] dp_raw;
	cwb_div #(.NW(PROD_W), .DW(DIV_W), .QW(AMT_W), .PW(PW)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (s4_v),
		.num     (ei_s4),
		.den     (t_s4),
		.pay     (pay_s4),
		.out_vld (dv_v),
		.quo     (ei_q),
		.pay_out (dp_raw)
	);
	assign dp = dpay_t'(dp_raw);

	// last stage: apply evap, infiltration, ponding
	amt_t i5, q5, inf5, pd5, qf5;
	always_comb begin
		i5 = dp.i;
		q5 = dp.q;
		if (!dp.qz) begin
			if (dp.eall) begin
				i5 = '0;
				q5 = '0;
			end else begin
				i5 = dp.i - ei_q;
				q5 = dp.q - (dp.e - ei_q);
			end
		end else begin
			i5 = (dp.i > dp.e) ? dp.i - dp.e : '0;
		end
		inf5 = (q5 < dp.f) ? q5 : dp.f;
		qf5 = q5 - inf5;
		pd5 = (qf5 < dp.pcap) ? qf5 : dp.pcap;
		qf5 = qf5 - pd5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dv_v;
		end
	end
	always_ff @(posedge clk) begin
		out_valid <= dp.cv;
		if (dp.cv) begin
			new_intercept <= i5;
			infil_added <= inf5;
			new_ponding <= pd5;
			new_flow <= qf5;
		end else begin
			new_intercept <= dp.istore;
			infil_added <= '0;
			new_ponding <= dp.pstore;
			new_flow <= dp.routed;
		end
	end

	// checks
	`CWB_ASSERT_NXT(a_s1_follows_start, clk, arst_n, start, s1_v)
	`CWB_ASSERT_NXT(a_done_follows_div, clk, arst_n, dv_v, done)
	`CWB_ASSERT_IMP(a_split_bounded, clk, arst_n,
		dv_v && dp.cv && !dp.qz && !dp.eall, ei_q <= dp.i && ei_q <= dp.e)
endmodule

FILE: test/tb.sv
// testbench for cell_water_balance: directed and random cell words against a local predictor
// depends on cwb_pkg and the cell_water_balance rtl
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cwb_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam int LATENCY = 37;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam logic [63:0] AMT_TOP = 64'hFFFF_FFFF;

	// one cell word as driven on the ports
	typedef struct {
		logic  valid;
		amt_t  step, precip, evap, infil, istore, icap, routed, pstore, pcap;
	} cell_word_t;

	// one balance result
	typedef struct {
		logic  valid;
		amt_t  intercept, infil, pond, flow;
	} balance_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done;
	logic cell_valid = 1'b0;
	amt_t step_time = '0, precip_rate = '0, evap_rate = '0, infil_rate = '0;
	amt_t intercept_store = '0, intercept_cap = '0, routed_flow = '0;
	amt_t ponding_store = '0, ponding_cap = '0;
	logic out_valid;
	amt_t new_intercept, infil_added, new_ponding, new_flow;

	balance_t pending_balances[$];
	int errors = 0;
	int words_sent = 0;
	int results_seen = 0;
	int idle_cycles = 0;

	cell_water_balance u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cell_valid(cell_valid), .step_time(step_time), .precip_rate(precip_rate),
		.evap_rate(evap_rate), .infil_rate(infil_rate),
		.intercept_store(intercept_store), .intercept_cap(intercept_cap),
		.routed_flow(routed_flow), .ponding_store(ponding_store),
		.ponding_cap(ponding_cap), .done(done), .out_valid(out_valid),
		.new_intercept(new_intercept), .infil_added(infil_added),
		.new_ponding(new_ponding), .new_flow(new_flow)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// rate times duration, truncated and saturated to 32 bits
	function automatic logic [63:0] scaled_amount(amt_t t, amt_t r);
		logic [63:0] p;
		p = ({32'b0, t} * {32'b0, r}) >> FRAC;
		return (p > AMT_TOP) ? AMT_TOP : p;
	endfunction

	function automatic logic [63:0] capped_sum(logic [63:0] a, logic [63:0] b);
		logic [63:0] s;
		s = a + b;
		return (s > AMT_TOP) ? AMT_TOP : s;
	endfunction

	// vertical balance of one cell
	function automatic balance_t water_balance(cell_word_t w);
		balance_t r;
		logic [63:0] p, e, f, i, q, t, ei, g, inf, pond;
		r.valid = w.valid;
		if (!w.valid) begin
			r.intercept = w.istore;
			r.infil = '0;
			r.pond = w.pstore;
			r.flow = w.routed;
			return r;
		end
		p = scaled_amount(w.step, w.precip);
		e = scaled_amount(w.step, w.evap);
		f = scaled_amount(w.step, w.infil);
		i = {32'b0, w.istore};
		// fill interception, or spill an overfull store into precipitation
		if (w.icap != 0) begin
			if (i < w.icap) begin
				g = w.icap - i;
				if (g > p)
					g = p;
				i += g;
				p -= g;
			end else begin
				p = capped_sum(p, i - w.icap);
				i = w.icap;
			end
		end
		q = capped_sum(capped_sum(p, w.routed), w.pstore);
		// evapotranspiration shared in proportion to store sizes
		if (q != 0) begin
			t = i + q;
			if (e >= t) begin
				i = 0;
				q = 0;
			end else begin
				ei = (e * i) / t;
				i -= ei;
				q -= (e - ei);
			end
		end else if (i > e) begin
			i -= e;
		end else begin
			i = 0;
		end
		inf = (q < f) ? q : f;
		q -= inf;
		pond = (q < w.pcap) ? q : w.pcap;
		q -= pond;
		r.intercept = i[31:0];
		r.infil = inf[31:0];
		r.pond = pond[31:0];
		r.flow = q[31:0];
		return r;
	endfunction

	// result checker: done marks a word that is taken at the closing edge
	always @(posedge clk) begin
		balance_t want;
		if (arst_n && done) begin
			results_seen++;
			if (pending_balances.size() == 0) begin
				errors++;
				$display("%t: result with nothing expected", $realtime);
			end else begin
				want = pending_balances.pop_front();
				if (out_valid !== want.valid) begin
					errors++;
					$display("%t: out_valid exp %0d got %0d", $realtime, want.valid, out_valid);
				end
				if (new_intercept !== want.intercept) begin
					errors++;
					$display("%t: new_intercept exp %h got %h", $realtime, want.intercept,
						new_intercept);
				end
				if (infil_added !== want.infil) begin
					errors++;
					$display("%t: infil_added exp %h got %h", $realtime, want.infil, infil_added);
				end
				if (new_ponding !== want.pond) begin
					errors++;
					$display("%t: new_ponding exp %h got %h", $realtime, want.pond, new_ponding);
				end
				if (new_flow !== want.flow) begin
					errors++;
					$display("%t: new_flow exp %h got %h", $realtime, want.flow, new_flow);
				end
			end
		end
	end

	// watchdog: too long with nothing taken in or out
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired after %0d idle cycles", idle_cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// drive one word, hold until accepted, then a random gap unless allow_gap is off
	task automatic send_word(cell_word_t w, bit allow_gap = 1'b1);
		int gap;
		start <= 1'b1;
		cell_valid <= w.valid;
		step_time <= w.step;
		precip_rate <= w.precip;
		evap_rate <= w.evap;
		infil_rate <= w.infil;
		intercept_store <= w.istore;
		intercept_cap <= w.icap;
		routed_flow <= w.routed;
		ponding_store <= w.pstore;
		ponding_cap <= w.pcap;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_balances.push_back(water_balance(w));
		words_sent++;
		gap = allow_gap ? $urandom_range(0, 5) : 0;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// amounts biased toward zero, small, large and all ones
	function automatic amt_t rand_amount();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return $urandom_range(0, 255);
			3: return $urandom_range(0, 32'h000F_FFFF);
			4: return $urandom_range(32'h0001_0000, 32'h0040_0000);
			default: return $urandom();
		endcase
	endfunction

	function automatic cell_word_t rand_word();
		cell_word_t w;
		w.valid = ($urandom_range(0, 9) != 0);
		w.step = ($urandom_range(0, 3) == 0) ? rand_amount() : $urandom_range(0, 32'h0003_0000);
		w.precip = rand_amount();
		w.evap = rand_amount();
		w.infil = rand_amount();
		w.istore = rand_amount();
		w.icap = rand_amount();
		w.routed = rand_amount();
		w.pstore = rand_amount();
		w.pcap = rand_amount();
		return w;
	endfunction

	function automatic cell_word_t make_word(logic v, amt_t st, amt_t p, amt_t e, amt_t f,
		amt_t is, amt_t ic, amt_t r, amt_t ps, amt_t pc);
		cell_word_t w;
		w.valid = v; w.step = st; w.precip = p; w.evap = e; w.infil = f;
		w.istore = is; w.icap = ic; w.routed = r; w.pstore = ps; w.pcap = pc;
		return w;
	endfunction

	task automatic wait_drained();
		start <= 1'b0;
		while (pending_balances.size() != 0)
			@(posedge clk);
	endtask

	// field extremes and each named corner of the balance
	task automatic test_corners();
		localparam amt_t ONE = 32'h0001_0000;
		send_word(make_word(0, '1, '1, '1, '1, 32'h1234_5678, '1, 32'hDEAD_BEEF, 32'h0BAD_F00D, 0));
		send_word(make_word(1, '0, '0, '0, '0, '0, '0, '0, '0, '0));
		send_word(make_word(1, '1, '1, '1, '1, '1, '1, '1, '1, '1));
		// overfull interception spills into precipitation
		send_word(make_word(1, ONE, 5 * ONE, 0, 0, 20 * ONE, 8 * ONE, ONE, 0, 50 * ONE));
		// interception disabled, store only evaporates
		send_word(make_word(1, ONE, 4 * ONE, 2 * ONE, 0, 3 * ONE, 0, 0, 0, 0));
		// no surface water, evapotranspiration empties the store
		send_word(make_word(1, ONE, 0, 9 * ONE, 0, 3 * ONE, 0, 0, 0, 0));
		// demand exceeds everything
		send_word(make_word(1, 2 * ONE, ONE, 100 * ONE, 0, ONE, 2 * ONE, ONE, ONE, 0));
		// proportional split, then infiltration, ponding and flow
		send_word(make_word(1, 3 * ONE, 10 * ONE, ONE, 2 * ONE, ONE, 4 * ONE, 7 * ONE, 2 * ONE,
			5 * ONE));
		// nothing left to pond: old ponding goes to zero
		send_word(make_word(1, ONE, 0, 0, 100 * ONE, 0, 0, 0, 6 * ONE, 10 * ONE));
		// saturating products and sums
		send_word(make_word(1, '1, 32'h8000_0000, 0, 0, 0, ONE, '1, '1, 0));
		send_word(make_word(1, 32'hFFFF_0000, '1, 32'h7FFF_FFFF, 32'h1, '1, 32'h8000_0000,
			32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0000));
		send_word(make_word(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		wait_drained();
	endtask

	// random words, back to back stretches included
	task automatic test_random(int count);
		bit burst;
		for (int n = 0; n < count; n++) begin
			burst = (n % 200) < 40;
			send_word(rand_word(), !burst);
			// one pause until the pipeline is empty
			if (n == count / 2)
				wait_drained();
		end
		wait_drained();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corners();
		test_random(1800);
		start <= 1'b0;
		repeat (LATENCY + 5) @(posedge clk);
		$display("sent %0d cell words (directed corners and random), checked %0d results",
			words_sent, results_seen);
		if (errors == 0 && pending_balances.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
